// File: sv/bmg_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// Battery median gauge package
// Shared widths, register map, reset values, handshake structs and the
// charge band lookup used by the gauge and its percentage unit.
// ----------------------------------------------------------------------------
package bmg_pkg;

  localparam int unsigned SAMPLE_COUNT_DEF = 16;

  localparam int unsigned VOLT_W = 16;
  localparam int unsigned PCT_W  = 7;
  localparam int unsigned BAND_W = 3;
  localparam int unsigned DIV_W  = VOLT_W + PCT_W;

  localparam int unsigned APB_AW = 4;
  localparam int unsigned APB_DW = 32;

  // Register indexes, one 32-bit word each.
  localparam logic [1:0] REG_INTERVAL = 2'd0;
  localparam logic [1:0] REG_EMPTY    = 2'd1;
  localparam logic [1:0] REG_FULL     = 2'd2;

  localparam logic [VOLT_W-1:0] INTERVAL_RST = 16'd60;
  localparam logic [VOLT_W-1:0] EMPTY_RST    = 16'd18000;
  localparam logic [VOLT_W-1:0] FULL_RST     = 16'd25200;

  localparam logic [VOLT_W-1:0] TICKS_MAX = 16'hFFFF;
  localparam logic [PCT_W-1:0]  PCT_FULL  = 7'd100;

  localparam logic [PCT_W-1:0] BAND1_MAX = 7'd5;
  localparam logic [PCT_W-1:0] BAND2_MAX = 7'd15;
  localparam logic [PCT_W-1:0] BAND3_MAX = 7'd30;
  localparam logic [PCT_W-1:0] BAND4_MAX = 7'd60;

  localparam logic [BAND_W-1:0] BAND_1 = 3'd1;
  localparam logic [BAND_W-1:0] BAND_2 = 3'd2;
  localparam logic [BAND_W-1:0] BAND_3 = 3'd3;
  localparam logic [BAND_W-1:0] BAND_4 = 3'd4;
  localparam logic [BAND_W-1:0] BAND_5 = 3'd5;

  typedef struct packed {
    logic              start;
    logic [VOLT_W-1:0] median_mv;
    logic [VOLT_W-1:0] empty_mv;
    logic [VOLT_W-1:0] full_mv;
  } pct_req_t;

  typedef struct packed {
    logic             done;
    logic [PCT_W-1:0] percent;
  } pct_rsp_t;

  function automatic logic [BAND_W-1:0] band_of(logic [PCT_W-1:0] pct);
    logic [BAND_W-1:0] band;
    if (pct <= BAND1_MAX) begin
      band = BAND_1;
    end else if (pct <= BAND2_MAX) begin
      band = BAND_2;
    end else if (pct <= BAND3_MAX) begin
      band = BAND_3;
    end else if (pct <= BAND4_MAX) begin
      band = BAND_4;
    end else begin
      band = BAND_5;
    end
    return band;
  endfunction

endpackage
`default_nettype wire

// File: sv/bmg_if.sv
`default_nettype none
// ----------------------------------------------------------------------------
// Battery median gauge channels
// Valid/ready channels for the voltage readings and for the gauge results.
// ----------------------------------------------------------------------------
interface bmg_in_if;
  logic                         valid;
  logic                         ready;
  logic [bmg_pkg::VOLT_W-1:0]   voltage_mv;

  modport source (output valid, output voltage_mv, input ready);
  modport sink (input valid, input voltage_mv, output ready);
endinterface

interface bmg_out_if;
  logic                         valid;
  logic                         ready;
  logic [bmg_pkg::VOLT_W-1:0]   median_mv;
  logic [bmg_pkg::PCT_W-1:0]    charge_percent;
  logic [bmg_pkg::BAND_W-1:0]   charge_band;
  logic                         sample_taken;
  logic                         median_updated;

  modport source (
    output valid, output median_mv, output charge_percent, output charge_band,
    output sample_taken, output median_updated, input ready
  );
  modport sink (
    input valid, input median_mv, input charge_percent, input charge_band,
    input sample_taken, input median_updated, output ready
  );
endinterface
`default_nettype wire

// File: sv/bmg_ram.sv
`default_nettype none
// ----------------------------------------------------------------------------
// Generic RAM
// One write port and one read port with a registered read.
// ----------------------------------------------------------------------------
module bmg_ram #(
  parameter int unsigned WIDTH = 16,
  parameter int unsigned DEPTH = 16,
  localparam int unsigned AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  wire logic             clk_i,
  input  wire logic             we_i,
  input  wire logic [AW-1:0]    waddr_i,
  input  wire logic [WIDTH-1:0] wdata_i,
  input  wire logic [AW-1:0]    raddr_i,
  output logic      [WIDTH-1:0] rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_o <= mem_q[raddr_i];
  end

endmodule
`default_nettype wire

// File: sv/bmg_pct.sv
`default_nettype none
// ----------------------------------------------------------------------------
// Charge percentage unit
// Clamped (median - empty) * 100 / (full - empty), floored, computed with a
// registered multiply and a restoring divider that settles one bit a cycle.
// ----------------------------------------------------------------------------
module bmg_pct (
  input  wire logic              clk_i,
  input  wire logic              rst_ni,
  input  wire bmg_pkg::pct_req_t req_i,
  output bmg_pkg::pct_rsp_t      rsp_o
);

  typedef enum logic [3:0] {
    P_IDLE = 4'b0001,
    P_MUL  = 4'b0010,
    P_DIV  = 4'b0100,
    P_DONE = 4'b1000
  } pct_state_e;

  pct_state_e                    state_q, state_d;
  logic [bmg_pkg::VOLT_W-1:0]    diff_q, diff_d;
  logic [bmg_pkg::VOLT_W-1:0]    den_q, den_d;
  logic [bmg_pkg::DIV_W-1:0]     rem_q, rem_d;
  logic [bmg_pkg::PCT_W-1:0]     quo_q, quo_d;
  logic [2:0]                    bit_q, bit_d;
  logic [bmg_pkg::DIV_W-1:0]     trial;

  assign trial = bmg_pkg::DIV_W'(den_q) << bit_q;

  always_comb begin
    state_d = state_q;
    diff_d  = diff_q;
    den_d   = den_q;
    rem_d   = rem_q;
    quo_d   = quo_q;
    bit_d   = bit_q;
    case (state_q)
      P_IDLE: begin
        if (req_i.start) begin
          diff_d = req_i.median_mv - req_i.empty_mv;
          den_d  = req_i.full_mv - req_i.empty_mv;
          if (req_i.full_mv <= req_i.empty_mv || req_i.median_mv <= req_i.empty_mv) begin
            quo_d   = '0;
            state_d = P_DONE;
          end else if (req_i.median_mv >= req_i.full_mv) begin
            quo_d   = bmg_pkg::PCT_FULL;
            state_d = P_DONE;
          end else begin
            state_d = P_MUL;
          end
        end
      end
      P_MUL: begin
        rem_d   = bmg_pkg::DIV_W'(diff_q) * bmg_pkg::DIV_W'(bmg_pkg::PCT_FULL);
        quo_d   = '0;
        bit_d   = 3'(bmg_pkg::PCT_W - 1);
        state_d = P_DIV;
      end
      P_DIV: begin
        // The quotient stays below 100, so seven bits settle it.
        if (rem_q >= trial) begin
          rem_d        = rem_q - trial;
          quo_d[bit_q] = 1'b1;
        end
        if (bit_q == 3'd0) begin
          state_d = P_DONE;
        end else begin
          bit_d = bit_q - 3'd1;
        end
      end
      P_DONE: begin
        state_d = P_IDLE;
      end
      default: begin
        state_d = P_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= P_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  always_ff @(posedge clk_i) begin
    diff_q <= diff_d;
    den_q  <= den_d;
    rem_q  <= rem_d;
    quo_q  <= quo_d;
    bit_q  <= bit_d;
  end

  assign rsp_o.done    = (state_q == P_DONE);
  assign rsp_o.percent = quo_q;

endmodule
`default_nettype wire

// File: sv/battery_median_gauge.sv
`default_nettype none
// ----------------------------------------------------------------------------
// Battery median gauge
// Samples the battery voltage every sample_interval ticks, takes the median of
// each window of SAMPLE_COUNT samples held in a RAM, and reports the held
// median with a clamped charge percentage and a five-level charge band.
// ----------------------------------------------------------------------------
// Results: each tick's result is registered and shows in the cycle after its
//   transfer; a window-closing tick's result waits for the rank scan and percentage unit.
// Throughput: one tick per cycle unless the output stalls or a window closes; the
//   closing tick is bound by the rank scan, which reads the sample RAM once per cycle.
// Reset: clears control state, counters, held median and held percentage;
//   the sample RAM is not cleared, only entries of the current window are read.
// ----------------------------------------------------------------------------
module battery_median_gauge #(
  parameter int unsigned SAMPLE_COUNT = bmg_pkg::SAMPLE_COUNT_DEF
) (
  input  wire logic                        clk_i,
  input  wire logic                        rst_ni,
  bmg_in_if.sink                           in_i,
  bmg_out_if.source                        out_o,
  input  wire logic                        psel,
  input  wire logic                        penable,
  input  wire logic                        pwrite,
  input  wire logic [bmg_pkg::APB_AW-1:0]  paddr,
  input  wire logic [bmg_pkg::APB_DW-1:0]  pwdata,
  output logic      [bmg_pkg::APB_DW-1:0]  prdata,
  output logic                             pready
);

  localparam int unsigned AW = (SAMPLE_COUNT > 1) ? $clog2(SAMPLE_COUNT) : 1;
  localparam int unsigned FW = $clog2(SAMPLE_COUNT + 1);
  localparam int unsigned CW = $clog2(SAMPLE_COUNT + 1);
  localparam int unsigned K_LO = (SAMPLE_COUNT - 1) / 2;
  localparam int unsigned K_HI = SAMPLE_COUNT / 2;
  localparam logic [AW-1:0] LAST_IDX = AW'(SAMPLE_COUNT - 1);
  localparam logic [FW-1:0] LAST_FILL = FW'(SAMPLE_COUNT - 1);

  typedef enum logic [7:0] {
    S_IDLE     = 8'b0000_0001,
    S_CAND_RD  = 8'b0000_0010,
    S_CAND_WT  = 8'b0000_0100,
    S_SCAN     = 8'b0000_1000,
    S_RANK     = 8'b0001_0000,
    S_MED      = 8'b0010_0000,
    S_PCT_WAIT = 8'b0100_0000,
    S_DONE     = 8'b1000_0000
  } gauge_state_e;

  gauge_state_e state_q, state_d;

  logic [bmg_pkg::VOLT_W-1:0] interval_q, empty_q, full_q;
  logic [bmg_pkg::VOLT_W-1:0] ticks_q, ticks_d;
  logic [FW-1:0]              fill_q, fill_d;
  logic [bmg_pkg::VOLT_W-1:0] held_median_q, held_median_d;
  logic [bmg_pkg::PCT_W-1:0]  held_percent_q, held_percent_d;

  logic [AW-1:0]              cand_idx_q, cand_idx_d;
  logic [AW-1:0]              scan_idx_q, scan_idx_d;
  logic [bmg_pkg::VOLT_W-1:0] cand_q, cand_d;
  logic [CW-1:0]              lt_q, lt_d;
  logic [CW-1:0]              le_q, le_d;
  logic [bmg_pkg::VOLT_W-1:0] lo_q, lo_d;
  logic [bmg_pkg::VOLT_W-1:0] hi_q, hi_d;

  logic                       out_valid_q, out_valid_d;
  logic [bmg_pkg::VOLT_W-1:0] out_median_q, out_median_d;
  logic [bmg_pkg::PCT_W-1:0]  out_pct_q, out_pct_d;
  logic [bmg_pkg::BAND_W-1:0] out_band_q, out_band_d;
  logic                       out_taken_q, out_taken_d;
  logic                       out_upd_q, out_upd_d;

  logic                       ram_we;
  logic [AW-1:0]              ram_raddr;
  logic [bmg_pkg::VOLT_W-1:0] ram_rdata;

  logic                       in_xfer;
  logic                       take;
  logic                       window_done;
  logic                       out_free;
  logic [bmg_pkg::VOLT_W:0]   mid_sum;
  logic                       cfg_write;
  logic [1:0]                 cfg_idx;

  bmg_pkg::pct_req_t pct_req;
  bmg_pkg::pct_rsp_t pct_rsp;

  // --------------------------------------------------------------------------
  // Configuration port
  // --------------------------------------------------------------------------
  assign pready    = 1'b1;
  assign cfg_write = psel && penable && pwrite && pready;
  assign cfg_idx   = paddr[3:2];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      interval_q <= bmg_pkg::INTERVAL_RST;
      empty_q    <= bmg_pkg::EMPTY_RST;
      full_q     <= bmg_pkg::FULL_RST;
    end else if (cfg_write) begin
      case (cfg_idx)
        bmg_pkg::REG_INTERVAL: interval_q <= pwdata[bmg_pkg::VOLT_W-1:0];
        bmg_pkg::REG_EMPTY:    empty_q    <= pwdata[bmg_pkg::VOLT_W-1:0];
        bmg_pkg::REG_FULL:     full_q     <= pwdata[bmg_pkg::VOLT_W-1:0];
        default: begin
        end
      endcase
    end
  end

  always_comb begin
    case (cfg_idx)
      bmg_pkg::REG_INTERVAL: prdata = bmg_pkg::APB_DW'(interval_q);
      bmg_pkg::REG_EMPTY:    prdata = bmg_pkg::APB_DW'(empty_q);
      bmg_pkg::REG_FULL:     prdata = bmg_pkg::APB_DW'(full_q);
      default:               prdata = '0;
    endcase
  end

  // --------------------------------------------------------------------------
  // Sample store and percentage unit
  // --------------------------------------------------------------------------
  bmg_ram #(
    .WIDTH (bmg_pkg::VOLT_W),
    .DEPTH (SAMPLE_COUNT)
  ) u_store (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (fill_q[AW-1:0]),
    .wdata_i (in_i.voltage_mv),
    .raddr_i (ram_raddr),
    .rdata_o (ram_rdata)
  );

  bmg_pct u_pct (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .req_i  (pct_req),
    .rsp_o  (pct_rsp)
  );

  // --------------------------------------------------------------------------
  // Control
  // --------------------------------------------------------------------------
  assign out_free    = !out_valid_q || out_o.ready;
  assign in_i.ready  = (state_q == S_IDLE) && out_free;
  assign in_xfer     = in_i.valid && in_i.ready;
  assign take        = (ticks_q >= interval_q);
  assign window_done = take && (fill_q == LAST_FILL);
  assign ram_we      = in_xfer && take;
  assign mid_sum     = {1'b0, lo_q} + {1'b0, hi_q};

  always_comb begin
    state_d        = state_q;
    ticks_d        = ticks_q;
    fill_d         = fill_q;
    held_median_d  = held_median_q;
    held_percent_d = held_percent_q;
    cand_idx_d     = cand_idx_q;
    scan_idx_d     = scan_idx_q;
    cand_d         = cand_q;
    lt_d           = lt_q;
    le_d           = le_q;
    lo_d           = lo_q;
    hi_d           = hi_q;
    out_valid_d    = out_valid_q && !out_o.ready;
    out_median_d   = out_median_q;
    out_pct_d      = out_pct_q;
    out_band_d     = out_band_q;
    out_taken_d    = out_taken_q;
    out_upd_d      = out_upd_q;
    ram_raddr      = '0;
    pct_req        = '{start: 1'b0, median_mv: mid_sum[bmg_pkg::VOLT_W:1],
                       empty_mv: empty_q, full_mv: full_q};

    case (state_q)
      S_IDLE: begin
        if (in_xfer) begin
          if (take) begin
            ticks_d = bmg_pkg::VOLT_W'(1);
          end else if (ticks_q != bmg_pkg::TICKS_MAX) begin
            ticks_d = ticks_q + 1'b1;
          end
          if (window_done) begin
            fill_d     = '0;
            cand_idx_d = '0;
            state_d    = S_CAND_RD;
          end else begin
            if (take) begin
              fill_d = fill_q + 1'b1;
            end
            out_valid_d  = 1'b1;
            out_median_d = held_median_q;
            out_pct_d    = held_percent_q;
            out_band_d   = bmg_pkg::band_of(held_percent_q);
            out_taken_d  = take;
            out_upd_d    = 1'b0;
          end
        end
      end
      S_CAND_RD: begin
        ram_raddr = cand_idx_q;
        state_d   = S_CAND_WT;
      end
      S_CAND_WT: begin
        cand_d     = ram_rdata;
        ram_raddr  = '0;
        scan_idx_d = '0;
        lt_d       = '0;
        le_d       = '0;
        state_d    = S_SCAN;
      end
      S_SCAN: begin
        // The read data belongs to scan_idx_q; the next address is issued now.
        if (ram_rdata < cand_q) begin
          lt_d = lt_q + 1'b1;
        end
        if (ram_rdata <= cand_q) begin
          le_d = le_q + 1'b1;
        end
        if (scan_idx_q == LAST_IDX) begin
          state_d = S_RANK;
        end else begin
          scan_idx_d = scan_idx_q + 1'b1;
          ram_raddr  = scan_idx_q + 1'b1;
        end
      end
      S_RANK: begin
        // The candidate fills sorted positions lt through le-1.
        if (lt_q <= CW'(K_LO) && le_q > CW'(K_LO)) begin
          lo_d = cand_q;
        end
        if (lt_q <= CW'(K_HI) && le_q > CW'(K_HI)) begin
          hi_d = cand_q;
        end
        if (cand_idx_q == LAST_IDX) begin
          state_d = S_MED;
        end else begin
          cand_idx_d = cand_idx_q + 1'b1;
          state_d    = S_CAND_RD;
        end
      end
      S_MED: begin
        held_median_d = mid_sum[bmg_pkg::VOLT_W:1];
        pct_req.start = 1'b1;
        state_d       = S_PCT_WAIT;
      end
      S_PCT_WAIT: begin
        if (pct_rsp.done) begin
          held_percent_d = pct_rsp.percent;
          state_d        = S_DONE;
        end
      end
      S_DONE: begin
        if (out_free) begin
          out_valid_d  = 1'b1;
          out_median_d = held_median_q;
          out_pct_d    = held_percent_q;
          out_band_d   = bmg_pkg::band_of(held_percent_q);
          out_taken_d  = 1'b1;
          out_upd_d    = 1'b1;
          state_d      = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q        <= S_IDLE;
      ticks_q        <= '0;
      fill_q         <= '0;
      held_median_q  <= '0;
      held_percent_q <= '0;
      out_valid_q    <= 1'b0;
    end else begin
      state_q        <= state_d;
      ticks_q        <= ticks_d;
      fill_q         <= fill_d;
      held_median_q  <= held_median_d;
      held_percent_q <= held_percent_d;
      out_valid_q    <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    cand_idx_q   <= cand_idx_d;
    scan_idx_q   <= scan_idx_d;
    cand_q       <= cand_d;
    lt_q         <= lt_d;
    le_q         <= le_d;
    lo_q         <= lo_d;
    hi_q         <= hi_d;
    out_median_q <= out_median_d;
    out_pct_q    <= out_pct_d;
    out_band_q   <= out_band_d;
    out_taken_q  <= out_taken_d;
    out_upd_q    <= out_upd_d;
  end

  assign out_o.valid          = out_valid_q;
  assign out_o.median_mv      = out_median_q;
  assign out_o.charge_percent = out_pct_q;
  assign out_o.charge_band    = out_band_q;
  assign out_o.sample_taken   = out_taken_q;
  assign out_o.median_updated = out_upd_q;

  // --------------------------------------------------------------------------
  // Assertions
  // --------------------------------------------------------------------------
  a_fill_in_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    fill_q < FW'(SAMPLE_COUNT))
    else $error("sample fill count left the window range");

  a_pct_done_waited: assert property (@(posedge clk_i) disable iff (!rst_ni)
    pct_rsp.done |-> state_q == S_PCT_WAIT)
    else $error("percentage result arrived outside its wait state");

  a_quick_result: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_xfer && !window_done) |=> out_valid_q && !out_upd_q)
    else $error("tick without window closing did not give its result");

  a_pct_bounded: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q |-> out_pct_q <= bmg_pkg::PCT_FULL)
    else $error("charge percentage above full scale");

endmodule
`default_nettype wire

// File: dv/battery_median_gauge_tb.sv
// ----------------------------------------------------------------------------
// Battery median gauge testbench
// Streams voltage ticks through the gauge under a series of register
// settings. Every tick is predicted by an in-bench model of the sampling,
// the windowed median and the percentage and band mapping. Every result is
// checked field by field against the oldest prediction. Sender bursts and
// receiver stalls are random.
// ----------------------------------------------------------------------------
module battery_median_gauge_tb;
  import bmg_pkg::*;

  localparam int unsigned WINDOW        = SAMPLE_COUNT_DEF;
  localparam int          SETTLE_CYCLES = 340;
  localparam logic [1:0]  REG_SPARE     = 2'd3;

  typedef struct packed {
    logic [VOLT_W-1:0] median_mv;
    logic [PCT_W-1:0]  charge_percent;
    logic [BAND_W-1:0] charge_band;
    logic              sample_taken;
    logic              median_updated;
  } gauge_report_t;

  logic clk_i  = 1'b0;
  logic rst_ni = 1'b1;

  logic              psel;
  logic              penable;
  logic              pwrite;
  logic [APB_AW-1:0] paddr;
  logic [APB_DW-1:0] pwdata;
  logic [APB_DW-1:0] prdata;
  logic              pready;

  bmg_in_if  tick_ch ();
  bmg_out_if gauge_ch ();

  battery_median_gauge i_dut (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .in_i    (tick_ch),
    .out_o   (gauge_ch),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready)
  );

  always #10 clk_i = ~clk_i;

  // Gauge model: register copies and state, starting from their reset values.
  logic [VOLT_W-1:0] cfg_interval       = INTERVAL_RST;
  logic [VOLT_W-1:0] cfg_empty_mv       = EMPTY_RST;
  logic [VOLT_W-1:0] cfg_full_mv        = FULL_RST;
  logic [VOLT_W-1:0] window_mv [WINDOW];
  int                window_fill        = 0;
  logic [VOLT_W-1:0] ticks_since_sample = '0;
  logic [VOLT_W-1:0] held_median_mv     = '0;
  logic [PCT_W-1:0]  held_pct           = '0;

  logic [VOLT_W-1:0] tick_queue [$];
  gauge_report_t     awaited_reports [$];
  gauge_report_t     oldest_report;
  int                ticks_issued = 0;
  int                results_seen = 0;
  int                failures     = 0;

  bit          steady_flow  = 1'b0;
  int          burst_left   = 0;
  int          gap_left     = 0;
  logic [15:0] ready_pattern;
  logic [3:0]  stall_phase;
  int          center_mv    = 21600;
  bit          quiet_window = 1'b0;

  function automatic logic [VOLT_W-1:0] window_median_mv();
    logic [VOLT_W-1:0] sorted [WINDOW];
    logic [VOLT_W-1:0] v;
    logic [VOLT_W:0]   pair_sum;
    int                j;
    for (int i = 0; i < WINDOW; i++) sorted[i] = window_mv[i];
    for (int i = 1; i < WINDOW; i++) begin
      v = sorted[i];
      j = i;
      while (j > 0 && sorted[j-1] > v) begin
        sorted[j] = sorted[j-1];
        j--;
      end
      sorted[j] = v;
    end
    if (WINDOW % 2 == 0) begin
      pair_sum = {1'b0, sorted[WINDOW/2-1]} + {1'b0, sorted[WINDOW/2]};
      return pair_sum[VOLT_W:1];
    end
    return sorted[WINDOW/2];
  endfunction

  function automatic logic [PCT_W-1:0] percent_of_mv(logic [VOLT_W-1:0] mv);
    int unsigned over;
    int unsigned span;
    if (cfg_full_mv <= cfg_empty_mv || mv <= cfg_empty_mv) return '0;
    if (mv >= cfg_full_mv) return PCT_FULL;
    over = mv - cfg_empty_mv;
    span = cfg_full_mv - cfg_empty_mv;
    return PCT_W'((over * 100) / span);
  endfunction

  function automatic logic [BAND_W-1:0] band_for_pct(logic [PCT_W-1:0] pct);
    if (pct > BAND4_MAX) return BAND_5;
    if (pct > BAND3_MAX) return BAND_4;
    if (pct > BAND2_MAX) return BAND_3;
    if (pct > BAND1_MAX) return BAND_2;
    return BAND_1;
  endfunction

  function automatic gauge_report_t gauge_step(logic [VOLT_W-1:0] mv);
    gauge_report_t r;
    r.sample_taken   = 1'b0;
    r.median_updated = 1'b0;
    if (ticks_since_sample >= cfg_interval) begin
      r.sample_taken = 1'b1;
      window_mv[window_fill] = mv;
      window_fill++;
      if (window_fill == WINDOW) begin
        held_median_mv   = window_median_mv();
        held_pct         = percent_of_mv(held_median_mv);
        window_fill      = 0;
        r.median_updated = 1'b1;
      end
      ticks_since_sample = 1;
    end else if (ticks_since_sample != TICKS_MAX) begin
      ticks_since_sample++;
    end
    r.median_mv      = held_median_mv;
    r.charge_percent = held_pct;
    r.charge_band    = band_for_pct(held_pct);
    return r;
  endfunction

  // Readings hover around a center that moves now and then; some windows sit
  // exactly on a range end, and a few readings are arbitrary outliers.
  function automatic logic [VOLT_W-1:0] pick_voltage();
    int lo;
    int hi;
    int v;
    lo = (cfg_empty_mv < cfg_full_mv) ? cfg_empty_mv : cfg_full_mv;
    hi = (cfg_empty_mv < cfg_full_mv) ? cfg_full_mv : cfg_empty_mv;
    lo = (lo > 600) ? lo - 600 : 0;
    hi = (hi < 64935) ? hi + 600 : 65535;
    if ($urandom_range(0, 47) == 0) begin
      quiet_window = ($urandom_range(0, 3) == 0);
      if (quiet_window) begin
        center_mv = $urandom_range(0, 1) ? cfg_empty_mv : cfg_full_mv;
      end else begin
        center_mv = $urandom_range(hi, lo);
      end
    end
    if ($urandom_range(0, 9) == 0) return VOLT_W'($urandom());
    v = center_mv;
    if (!quiet_window) v = v + int'($urandom_range(0, 400)) - 200;
    if (v < 0) v = 0;
    if (v > 65535) v = 65535;
    return VOLT_W'(v);
  endfunction

  // Tick driver: bursts of transfers separated by random gaps.
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      tick_ch.valid      <= 1'b0;
      tick_ch.voltage_mv <= '0;
    end else begin
      if (tick_ch.valid && tick_ch.ready) begin
        awaited_reports.push_back(gauge_step(tick_ch.voltage_mv));
      end
      if (!tick_ch.valid || tick_ch.ready) begin
        if (gap_left > 0 && !steady_flow) begin
          gap_left--;
          tick_ch.valid <= 1'b0;
        end else if (tick_queue.size() > 0) begin
          tick_ch.valid      <= 1'b1;
          tick_ch.voltage_mv <= tick_queue.pop_front();
          if (burst_left > 1) begin
            burst_left--;
          end else begin
            burst_left = $urandom_range(1, 24);
            if ($urandom_range(0, 15) == 0) begin
              gap_left = $urandom_range(10, 30);
            end else begin
              gap_left = $urandom_range(0, 1) ? 0 : $urandom_range(1, 4);
            end
          end
        end else begin
          tick_ch.valid <= 1'b0;
        end
      end
    end
  end

  // Result monitor: ready follows a 16-bit mask that is redrawn each lap, or stays high in steady phases.
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      gauge_ch.ready <= 1'b0;
      ready_pattern = '1;
      stall_phase   = '0;
    end else begin
      if (gauge_ch.valid && gauge_ch.ready) begin
        results_seen++;
        if (awaited_reports.size() == 0) begin
          failures++;
          $display("%0t: result with none expected, got median %0d pct %0d band %0d",
                   $time, gauge_ch.median_mv, gauge_ch.charge_percent, gauge_ch.charge_band);
        end else begin
          oldest_report = awaited_reports.pop_front();
          if (gauge_ch.median_mv !== oldest_report.median_mv) begin
            failures++;
            $display("%0t: median_mv expected %0d, got %0d", $time,
                     oldest_report.median_mv, gauge_ch.median_mv);
          end
          if (gauge_ch.charge_percent !== oldest_report.charge_percent) begin
            failures++;
            $display("%0t: charge_percent expected %0d, got %0d", $time,
                     oldest_report.charge_percent, gauge_ch.charge_percent);
          end
          if (gauge_ch.charge_band !== oldest_report.charge_band) begin
            failures++;
            $display("%0t: charge_band expected %0d, got %0d", $time,
                     oldest_report.charge_band, gauge_ch.charge_band);
          end
          if (gauge_ch.sample_taken !== oldest_report.sample_taken) begin
            failures++;
            $display("%0t: sample_taken expected %0b, got %0b", $time,
                     oldest_report.sample_taken, gauge_ch.sample_taken);
          end
          if (gauge_ch.median_updated !== oldest_report.median_updated) begin
            failures++;
            $display("%0t: median_updated expected %0b, got %0b", $time,
                     oldest_report.median_updated, gauge_ch.median_updated);
          end
        end
      end
      stall_phase = stall_phase + 1'b1;
      if (stall_phase == 0) begin
        case ($urandom_range(0, 3))
          0: ready_pattern = '1;
          1: ready_pattern = 16'($urandom());
          2: ready_pattern = 16'($urandom() | $urandom());
          default: ready_pattern = 16'($urandom() & $urandom() & $urandom());
        endcase
      end
      gauge_ch.ready <= steady_flow | ready_pattern[stall_phase];
    end
  end

  task automatic push_tick(input logic [VOLT_W-1:0] mv);
    tick_queue.push_back(mv);
    ticks_issued++;
  endtask

  // Every tick gives one result, so the gauge is idle once all have arrived
  // and the closing computation has had time to drain.
  task automatic wait_idle();
    while (results_seen < ticks_issued) @(posedge clk_i);
    repeat (SETTLE_CYCLES) @(posedge clk_i);
  endtask

  task automatic cfg_write(input logic [1:0] idx, input logic [VOLT_W-1:0] value);
    @(posedge clk_i);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= {idx, 2'b00};
    pwdata  <= {16'($urandom()), value};
    @(posedge clk_i);
    penable <= 1'b1;
    @(posedge clk_i);
    while (!pready) @(posedge clk_i);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    case (idx)
      REG_INTERVAL: cfg_interval = value;
      REG_EMPTY:    cfg_empty_mv = value;
      REG_FULL:     cfg_full_mv  = value;
      default: ;
    endcase
  endtask

  task automatic cfg_readback(input logic [1:0] idx, input logic [VOLT_W-1:0] want);
    logic [APB_DW-1:0] got;
    @(posedge clk_i);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    paddr   <= {idx, 2'b00};
    @(posedge clk_i);
    penable <= 1'b1;
    // Read data must be stable through the access cycle.
    @(negedge clk_i);
    got = prdata;
    @(posedge clk_i);
    psel    <= 1'b0;
    penable <= 1'b0;
    if (got[VOLT_W-1:0] !== want) begin
      failures++;
      $display("%0t: register %0d expected %0d, got %0d", $time, idx, want, got[VOLT_W-1:0]);
    end
  endtask

  task automatic set_config(input logic [VOLT_W-1:0] interval,
                            input logic [VOLT_W-1:0] empty_mv,
                            input logic [VOLT_W-1:0] full_mv);
    wait_idle();
    cfg_readback(REG_INTERVAL, cfg_interval);
    cfg_readback(REG_EMPTY, cfg_empty_mv);
    cfg_readback(REG_FULL, cfg_full_mv);
    cfg_write(REG_INTERVAL, interval);
    cfg_write(REG_EMPTY, empty_mv);
    cfg_write(REG_FULL, full_mv);
    cfg_write(REG_SPARE, 16'($urandom()));
  endtask

  task automatic run_phase(input logic [VOLT_W-1:0] interval,
                           input logic [VOLT_W-1:0] empty_mv,
                           input logic [VOLT_W-1:0] full_mv,
                           input int count, input bit steady);
    set_config(interval, empty_mv, full_mv);
    steady_flow = steady;
    center_mv   = (int'(empty_mv) + int'(full_mv)) / 2;
    repeat (count) push_tick(pick_voltage());
  endtask

  initial begin
    logic [VOLT_W-1:0] lo_mv;
    logic [VOLT_W-1:0] interval;
    psel    = 1'b0;
    penable = 1'b0;
    pwrite  = 1'b0;
    paddr   = '0;
    pwdata  = '0;
    rst_ni <= 1'b0;
    repeat (9) @(posedge clk_i);
    rst_ni <= 1'b1;

    // Reset settings: no sample is due yet, so the band must read as the lowest.
    push_tick(16'h0000);
    push_tick(16'hFFFF);
    push_tick(16'h5555);
    push_tick(16'hAAAA);
    push_tick(EMPTY_RST);
    push_tick(FULL_RST);
    push_tick(16'h0001);
    push_tick(16'hFFFE);

    // Zero interval samples every tick; one window of extreme readings.
    set_config(16'd0, 16'd0, 16'hFFFF);
    push_tick(16'h0000);
    push_tick(16'hFFFF);
    push_tick(16'h5555);
    push_tick(16'hAAAA);
    push_tick(16'h00FF);
    push_tick(16'hFF00);
    push_tick(16'h0F0F);
    push_tick(16'hF0F0);
    push_tick(16'h8000);
    push_tick(16'h7FFF);
    push_tick(16'h0001);
    push_tick(16'hFFFE);
    push_tick(16'h3333);
    push_tick(16'hCCCC);
    push_tick(16'hFFFF);
    push_tick(16'hFFFF);

    run_phase(16'd1, EMPTY_RST, FULL_RST, 90, 1'b0);
    run_phase(16'd0, 16'd30000, 16'd30000, 80, 1'b0);
    run_phase(16'd2, 16'd40000, 16'd10000, 80, 1'b0);
    run_phase(16'd0, 16'hFFFF, 16'd0, 60, 1'b0);
    run_phase(16'd0, 16'd0, 16'd1, 80, 1'b0);
    run_phase(16'd3, 16'd20000, 16'd21000, 90, 1'b1);
    run_phase(INTERVAL_RST, EMPTY_RST, FULL_RST, 100, 1'b0);
    repeat (6) begin
      case ($urandom_range(0, 9))
        0:       interval = $urandom_range(3, 8);
        1:       interval = INTERVAL_RST;
        default: interval = $urandom_range(0, 2);
      endcase
      lo_mv = $urandom_range(0, 40000);
      if ($urandom_range(0, 3) == 0) begin
        run_phase(interval, lo_mv, 16'($urandom()), $urandom_range(70, 110), 1'b0);
      end else begin
        run_phase(interval, lo_mv, lo_mv + 16'($urandom_range(1, 25000)),
                  $urandom_range(70, 110), 1'b0);
      end
    end

    // Largest interval: a short run in which no sample comes due.
    run_phase(16'hFFFF, EMPTY_RST, FULL_RST, 30, 1'b1);

    wait_idle();
    if (failures == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

  initial begin
    #40_000_000;
    $display("Test completed with failures");
    $finish;
  end

endmodule
